/* hw/rtl/prime_sieve_lister_defines.svh */
// Assertion macros shared by the sieve lister RTL.
`ifndef PRIME_SIEVE_LISTER_DEFINES_SVH
`define PRIME_SIEVE_LISTER_DEFINES_SVH

// same-cycle implication, reset-qualified
`define PSL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset-qualified
`define PSL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/psl_pkg.sv */
// Shared types and constants for the sieve lister.
package psl_pkg;

	localparam int LIM_W         = 8;
	localparam int MAX_LIMIT_DEF = 255;
	localparam int PC_W          = 4;

	typedef logic [PC_W-1:0] pc_t;

	typedef enum logic [2:0] {
		C_NEVER      = 3'd0,
		C_ALWAYS     = 3'd1,
		C_NO_REQ     = 3'd2,
		C_LIM_LT2    = 3'd3,
		C_I_LT_LIM   = 3'd4,
		C_ISQ_GT_LIM = 3'd5,
		C_MARKED     = 3'd6,
		C_JN_LE_LIM  = 3'd7
	} cond_t;

	typedef enum logic [1:0] {
		I_HOLD = 2'd0,
		I_TWO  = 2'd1,
		I_INC  = 2'd2
	} iop_t;

	typedef enum logic [1:0] {
		MW_NONE  = 2'd0,
		MW_CLR_I = 2'd1,
		MW_SET_J = 2'd2
	} mwop_t;

	typedef enum logic [1:0] {
		EM_NONE  = 2'd0,
		EM_PEND  = 2'd1,
		EM_FINAL = 2'd2,
		EM_EMPTY = 2'd3
	} emop_t;

	typedef struct packed {
		logic  in_rdy;
		logic  wait_out;
		cond_t cond;
		pc_t   target;
		iop_t  i_op;
		logic  j_set;
		logic  j_add;
		mwop_t mem_wr;
		logic  mem_rd;
		emop_t emit;
		logic  pend_clr;
	} ctrl_t;

	typedef struct packed {
		logic in_acc;
		logic lim_lt2;
		logic i_lt_lim;
		logic isq_gt_lim;
		logic marked;
		logic jn_le_lim;
		logic out_stall;
	} stat_t;

endpackage

/* hw/rtl/psl_if.sv */
// Request and result channel interfaces.
interface psl_req_if import psl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [LIM_W-1:0] limit;

	modport source (output valid, output limit, input ready);
	modport sink (input valid, input limit, output ready);
endinterface

interface psl_rsp_if import psl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [LIM_W-1:0] prime;
	logic             prime_valid;
	logic             last;

	modport source (output valid, output prime, output prime_valid, output last, input ready);
	modport sink (input valid, input prime, input prime_valid, input last, output ready);
endinterface

/* hw/rtl/psl_seq.sv */
// Microcode sequencer: step counter, control ROM and jump logic.
module psl_seq import psl_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctrl_t ctrl
);

	localparam pc_t S_WAIT  = pc_t'(0);
	localparam pc_t S_CHK   = pc_t'(1);
	localparam pc_t S_CLR   = pc_t'(2);
	localparam pc_t S_SETI  = pc_t'(3);
	localparam pc_t S_SQ    = pc_t'(4);
	localparam pc_t S_TSTI  = pc_t'(5);
	localparam pc_t S_MARK  = pc_t'(6);
	localparam pc_t S_NXTI  = pc_t'(7);
	localparam pc_t S_SCAN  = pc_t'(8);
	localparam pc_t S_SRD   = pc_t'(9);
	localparam pc_t S_STST  = pc_t'(10);
	localparam pc_t S_SEMIT = pc_t'(11);
	localparam pc_t S_SNXT  = pc_t'(12);
	localparam pc_t S_FIN   = pc_t'(13);
	localparam pc_t S_EMPTY = pc_t'(14);

	pc_t  pc_q;
	logic take;
	logic hold;

	always_comb begin
		ctrl = '{in_rdy: 1'b0, wait_out: 1'b0, cond: C_NEVER, target: S_WAIT,
			i_op: I_HOLD, j_set: 1'b0, j_add: 1'b0, mem_wr: MW_NONE,
			mem_rd: 1'b0, emit: EM_NONE, pend_clr: 1'b0};
		case (pc_q)
			S_WAIT: begin
				ctrl.in_rdy = 1'b1;
				ctrl.i_op   = I_TWO;
				ctrl.cond   = C_NO_REQ;
				ctrl.target = S_WAIT;
			end
			S_CHK: begin
				ctrl.cond   = C_LIM_LT2;
				ctrl.target = S_EMPTY;
			end
			S_CLR: begin
				ctrl.mem_wr = MW_CLR_I;
				ctrl.i_op   = I_INC;
				ctrl.cond   = C_I_LT_LIM;
				ctrl.target = S_CLR;
			end
			S_SETI: begin
				ctrl.i_op = I_TWO;
			end
			S_SQ: begin
				ctrl.mem_rd = 1'b1;
				ctrl.j_set  = 1'b1;
				ctrl.cond   = C_ISQ_GT_LIM;
				ctrl.target = S_SCAN;
			end
			S_TSTI: begin
				ctrl.cond   = C_MARKED;
				ctrl.target = S_NXTI;
			end
			S_MARK: begin
				ctrl.mem_wr = MW_SET_J;
				ctrl.j_add  = 1'b1;
				ctrl.cond   = C_JN_LE_LIM;
				ctrl.target = S_MARK;
			end
			S_NXTI: begin
				ctrl.i_op   = I_INC;
				ctrl.cond   = C_ALWAYS;
				ctrl.target = S_SQ;
			end
			S_SCAN: begin
				ctrl.i_op     = I_TWO;
				ctrl.pend_clr = 1'b1;
			end
			S_SRD: begin
				ctrl.mem_rd = 1'b1;
			end
			S_STST: begin
				ctrl.cond   = C_MARKED;
				ctrl.target = S_SNXT;
			end
			S_SEMIT: begin
				ctrl.wait_out = 1'b1;
				ctrl.emit     = EM_PEND;
			end
			S_SNXT: begin
				ctrl.i_op   = I_INC;
				ctrl.cond   = C_I_LT_LIM;
				ctrl.target = S_SRD;
			end
			S_FIN: begin
				ctrl.wait_out = 1'b1;
				ctrl.emit     = EM_FINAL;
				ctrl.cond     = C_ALWAYS;
				ctrl.target   = S_WAIT;
			end
			S_EMPTY: begin
				ctrl.wait_out = 1'b1;
				ctrl.emit     = EM_EMPTY;
				ctrl.cond     = C_ALWAYS;
				ctrl.target   = S_WAIT;
			end
			default: begin
				ctrl.cond   = C_ALWAYS;
				ctrl.target = S_WAIT;
			end
		endcase
	end

	always_comb begin
		case (ctrl.cond)
			C_NEVER:      take = 1'b0;
			C_ALWAYS:     take = 1'b1;
			C_NO_REQ:     take = !stat.in_acc;
			C_LIM_LT2:    take = stat.lim_lt2;
			C_I_LT_LIM:   take = stat.i_lt_lim;
			C_ISQ_GT_LIM: take = stat.isq_gt_lim;
			C_MARKED:     take = stat.marked;
			C_JN_LE_LIM:  take = stat.jn_le_lim;
			default:      take = 1'b0;
		endcase
	end

	assign hold = ctrl.wait_out && stat.out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_WAIT;
		end else if (!hold) begin
			pc_q <= take ? ctrl.target : pc_q + pc_t'(1);
		end
	end

endmodule

/* hw/rtl/psl_dp.sv */
// Datapath: limit and index registers, composite bitmap, result register.
module psl_dp import psl_pkg::*; #(
	parameter int MAX_LIMIT = MAX_LIMIT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ctrl_t      ctrl,
	output stat_t      stat,
	psl_req_if.sink    req,
	psl_rsp_if.source  rsp
);

	localparam int DEPTH = MAX_LIMIT + 1;
	localparam int AW    = $clog2(DEPTH);

	logic                 map_mem [DEPTH];
	logic [LIM_W-1:0]     lim_q;
	logic [LIM_W-1:0]     lim_sat;
	logic [LIM_W-1:0]     i_q;
	logic [LIM_W:0]       j_q;
	logic [LIM_W:0]       j_nxt;
	logic [2*LIM_W-1:0]   i_sq;
	logic                 rd_q;
	logic [LIM_W-1:0]     pend_q;
	logic                 have_pend_q;
	logic                 out_v_q;
	logic [LIM_W-1:0]     prime_q;
	logic                 pvalid_q;
	logic                 last_q;
	logic                 act;
	logic                 emit_fire;
	logic [LIM_W-1:0]     emit_prime;
	logic                 emit_pvalid;
	logic                 emit_last;

	assign req.ready = ctrl.in_rdy;

	assign lim_sat = (req.limit > LIM_W'(MAX_LIMIT)) ? LIM_W'(MAX_LIMIT) : req.limit;
	assign i_sq    = (2*LIM_W)'(i_q) * (2*LIM_W)'(i_q);
	assign j_nxt   = j_q + {1'b0, i_q};

	assign stat.in_acc     = req.valid && req.ready;
	assign stat.lim_lt2    = lim_q < LIM_W'(2);
	assign stat.i_lt_lim   = i_q < lim_q;
	assign stat.isq_gt_lim = i_sq > (2*LIM_W)'(lim_q);
	assign stat.marked     = rd_q;
	assign stat.jn_le_lim  = j_nxt <= {1'b0, lim_q};
	assign stat.out_stall  = out_v_q && !rsp.ready;

	assign act = !(ctrl.wait_out && stat.out_stall);

	always_comb begin
		emit_fire   = 1'b0;
		emit_prime  = pend_q;
		emit_pvalid = 1'b1;
		emit_last   = 1'b0;
		case (ctrl.emit)
			EM_NONE: begin
				emit_fire = 1'b0;
			end
			EM_PEND: begin
				emit_fire = act && have_pend_q;
			end
			EM_FINAL: begin
				emit_fire = act;
				emit_last = 1'b1;
			end
			EM_EMPTY: begin
				emit_fire   = act;
				emit_prime  = '0;
				emit_pvalid = 1'b0;
				emit_last   = 1'b1;
			end
			default: begin
				emit_fire = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (stat.in_acc) begin
			lim_q <= lim_sat;
		end
		case (ctrl.i_op)
			I_TWO:   i_q <= LIM_W'(2);
			I_INC:   i_q <= i_q + LIM_W'(1);
			default: i_q <= i_q;
		endcase
		if (ctrl.j_set) begin
			j_q <= {i_q, 1'b0};
		end else if (ctrl.j_add) begin
			j_q <= j_nxt;
		end
		if (ctrl.emit == EM_PEND && act) begin
			pend_q <= i_q;
		end
		if (emit_fire) begin
			prime_q  <= emit_prime;
			pvalid_q <= emit_pvalid;
			last_q   <= emit_last;
		end
	end

	// bitmap: one write or one registered read per cycle
	always_ff @(posedge clk) begin
		case (ctrl.mem_wr)
			MW_CLR_I: map_mem[i_q[AW-1:0]] <= 1'b0;
			MW_SET_J: map_mem[j_q[AW-1:0]] <= 1'b1;
			default:  ;
		endcase
		if (ctrl.mem_rd) begin
			rd_q <= map_mem[i_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_pend_q <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			if (ctrl.pend_clr) begin
				have_pend_q <= 1'b0;
			end else if (ctrl.emit == EM_PEND && act) begin
				have_pend_q <= 1'b1;
			end
			if (emit_fire) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign rsp.valid       = out_v_q;
	assign rsp.prime       = prime_q;
	assign rsp.prime_valid = pvalid_q;
	assign rsp.last        = last_q;

endmodule

/* hw/rtl/prime_sieve_lister.sv */
// Top level of the sieve of Eratosthenes prime lister.
// One request at a time: a limit goes in, the primes up to it come out in
// ascending order with last set on the final one; a limit below two gives one
// result with prime_valid clear. The request port is ready only between
// requests. A request first clears the map, then marks the multiples of each
// unmarked base i with i*i <= limit, then scans every entry and emits each
// prime found; the result side can hold it off while a result waits. Its
// pace is set by the single-port bitmap, one access per cycle, and its
// registered read data.
`include "prime_sieve_lister_defines.svh"

module prime_sieve_lister import psl_pkg::*; #(
	parameter int MAX_LIMIT = MAX_LIMIT_DEF
) (
	input logic       clk,
	input logic       arst_n,
	psl_req_if.sink   req,
	psl_rsp_if.source rsp
);

	ctrl_t ctrl;
	stat_t stat;
	logic  rsp_wait;
	logic  rsp_prm;

	psl_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	psl_dp #(
		.MAX_LIMIT (MAX_LIMIT)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.stat   (stat),
		.req    (req),
		.rsp    (rsp)
	);

	assign rsp_wait = rsp.valid && !rsp.ready;
	assign rsp_prm  = rsp.valid && rsp.prime_valid;

	`PSL_ASSERT_NXT(a_one_req, clk, arst_n, req.valid && req.ready, !req.ready, "busy request")
	`PSL_ASSERT_IMP(a_empty, clk, arst_n, rsp.valid && !rsp.prime_valid, rsp.last, "no last")
	`PSL_ASSERT_IMP(a_prime_min, clk, arst_n, rsp_prm, rsp.prime >= LIM_W'(2), "prime below two")
	`PSL_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_wait, rsp.valid && $stable(rsp.prime), "changed")

endmodule
